>>> design/assert_macros.svh
// Assertion macros used by the gaussian blur unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define GLB_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("gaussian blur: invariant violated");

// A consequence that holds in the same cycle as its cause.
`define GLB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gaussian blur: same-cycle implication violated");

// A consequence that holds in the cycle after its cause.
`define GLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gaussian blur: next-cycle implication violated");

`endif

>>> design/glb_pkg.sv
// ----------------------------------------------------------------------------
// glb_pkg
// Shared types, constants and coefficient table of the selectable Gaussian
// blur unit.
// ----------------------------------------------------------------------------
package glb_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_TAPS_DEF   = 13;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int PIX_W    = 16;
   localparam int ROW_W    = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = PIX_W + COEF_W;
   localparam int VSUM_W   = PROD_W + 1;
   localparam int HPROD_W  = VSUM_W + COEF_W;
   localparam int ACC_W    = HPROD_W + 4;
   localparam int SIZE_W   = 4;
   localparam int SEL_W    = 3;
   localparam int N_SIZES  = 5;
   localparam int TAB_TAPS = 13;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [SIZE_W-1:0] MASK_SIZE_RST = 4'd7;
   localparam logic [SEL_W-1:0]  MASK_SEL_RST  = 3'd1;
   localparam logic [ROW_W-1:0]  HEIGHT_RST    = 16'd480;
   localparam int                WIDTH_RST_VAL = 640;

   typedef logic [PIX_W-1:0]  pix_type;
   typedef logic [COEF_W-1:0] coef_type;

   typedef struct packed {
      logic              op;
      logic [PIX_W-1:0]  pixel_in;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_out;
      logic              frame_last;
   } rsp_word_type;

   localparam coef_type COEF_TAB [N_SIZES][TAB_TAPS] = '{
      '{16'd92, 16'd10315, 16'd41173, 16'd10315, 16'd92, 16'd0, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd393, 16'd3971, 16'd15847, 16'd25107, 16'd15847, 16'd3971, 16'd393,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd46, 16'd708, 16'd4902, 16'd15624, 16'd22970, 16'd15624, 16'd4902,
        16'd708, 16'd46, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd7, 16'd111, 16'd1101, 16'd5702, 16'd15257, 16'd21175, 16'd15257,
        16'd5702, 16'd1101, 16'd111, 16'd7, 16'd0, 16'd0},
      '{16'd7, 16'd79, 16'd557, 16'd2490, 16'd7268, 16'd13815, 16'd17111,
        16'd13815, 16'd7268, 16'd2490, 16'd557, 16'd79, 16'd7}
   };

endpackage

>>> design/gaussian_blur_2d_selectable_unit.sv
// ----------------------------------------------------------------------------
// gaussian_blur_2d_selectable_unit
// Raster-order N x N Gaussian blur, N selectable among 5, 7, 9, 11 and 13.
// ----------------------------------------------------------------------------
// Words arrive on the req_ channel: a pixel in raster order, or a flush tick
// that drains one pending output after the whole frame has come in. Filtered
// words leave on the rsp_ channel in raster order, frame_last marking the
// final pixel of the frame. Border pixels pass through unchanged.
// The csr_ port sets mask size, width and height; each accepted write
// restarts the frame. Write it only while the unit is idle.
// The unit takes one word per cycle while req_stall is low. A result passes
// through the line store read, the window shift, the vertical product and
// sum in each column cell, then the horizontal product and sum, before it
// reaches rsp_valid. Output starts once (N/2) rows plus (N/2) pixels have
// arrived.
// Results wait in an eight-entry output queue. When rsp_stall holds them
// back, req_stall rises as soon as the queue plus words in flight would fill.
// Reset is synchronous and clears counters and queue; registers return to
// size 7, 640 by 480. The line store needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_blur_2d_selectable_unit #(
   parameter int MAX_WIDTH  = glb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_TAPS   = glb_pkg::MAX_TAPS_DEF,
   parameter int PIXEL_BITS = glb_pkg::PIXEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  glb_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output glb_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_we,
   input  logic [glb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [glb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import glb_pkg::*;

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int WW         = XW + 1;
   localparam int RING       = MAX_TAPS - 1;
   localparam int SW         = $clog2(RING);
   localparam int PW         = XW + ROW_W;
   localparam int CW         = 17;
   localparam int FIFO_DEPTH = 8;
   localparam int FA_W       = $clog2(FIFO_DEPTH);
   localparam int FC_W       = $clog2(FIFO_DEPTH + 1);
   localparam int N_TOK      = 5;
   localparam int RND_W      = ACC_W - 32;

   localparam logic [WW-1:0]    WIDTH_MAX = WW'(MAX_WIDTH);
   localparam logic [WW-1:0]    WIDTH_RST =
      (WIDTH_RST_VAL > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(WIDTH_RST_VAL);
   localparam logic [PIX_W-1:0] PIX_MAX   = PIX_W'((1 << PIXEL_BITS) - 1);
   localparam logic [FC_W-1:0]  FIFO_FULL = FC_W'(FIFO_DEPTH);
   localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(64'd1 << 31);

   typedef struct packed {
      logic             shift;
      logic             emit;
      logic             interior;
      logic             last;
      logic [PIX_W-1:0] pix;
      logic [SW-1:0]    yslot;
      logic [SW-1:0]    oslot;
   } front_type;

   typedef struct packed {
      logic             emit;
      logic             interior;
      logic             last;
      logic [PIX_W-1:0] pass;
   } tok_type;

   function automatic logic size_ok(input logic [CSR_DATA_W-1:0] v);
      logic legal;
      legal = (v == 16'd5) || (v == 16'd7) || (v == 16'd9) || (v == 16'd11) ||
              (v == 16'd13);
      return legal && (32'(v) <= MAX_TAPS);
   endfunction

   // Configuration and frame counters.
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SEL_W-1:0]  sel_ff, sel_in;
   logic [WW-1:0]     width_ff, width_in;
   logic [ROW_W-1:0]  height_ff, height_in;
   logic [XW-1:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SW-1:0]     in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [PW-1:0]     pix_idx_ff, pix_idx_in;

   front_type         st1_ff, st1_in;
   tok_type           tok_ff [N_TOK];
   tok_type           tok_in [N_TOK];

   logic [2:0]        radius;
   logic [CW-1:0]     half17, ox17, oy17, w17, h17;
   logic [PW-1:0]     lag;
   logic              frame_done, req_acc, pix_go, flush_go, emit_go;
   logic              interior, is_last, in_col_end, out_col_end;
   logic [PIX_W-1:0]  pix_masked;

   assign radius     = size_ff[3:1];
   assign half17     = CW'(radius) + CW'(1);
   assign ox17       = CW'(out_col_ff);
   assign oy17       = CW'(out_row_ff);
   assign w17        = CW'(width_ff);
   assign h17        = CW'(height_ff);
   assign lag        = PW'(width_ff) * PW'(radius) + PW'(radius);
   assign frame_done = in_row_ff >= height_ff;
   assign req_acc    = req_valid && !req_stall;
   assign pix_go     = req_acc && (req_word.op == OP_PIXEL) && !frame_done;
   assign flush_go   = req_acc && (req_word.op == OP_FLUSH) && frame_done;
   assign emit_go    = flush_go || (pix_go && (pix_idx_ff >= lag));
   assign pix_masked = req_word.pixel_in & PIX_MAX;

   assign interior = (ox17 >= half17) && (ox17 + half17 < w17) &&
                     (oy17 >= half17) && (oy17 + half17 < h17);
   assign is_last  = (out_row_ff == height_ff - 16'd1) &&
                     (WW'(out_col_ff) == width_ff - WW'(1));
   assign in_col_end  = WW'(in_col_ff) + WW'(1) >= width_ff;
   assign out_col_end = WW'(out_col_ff) + WW'(1) >= width_ff;

   always_comb begin
      size_in     = size_ff;
      sel_in      = sel_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      pix_idx_in  = pix_idx_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MASK_SIZE: begin
               if (size_ok(csr_wdata)) begin
                  size_in     = csr_wdata[SIZE_W-1:0];
                  sel_in      = SEL_W'(csr_wdata[3:1] - 3'd2);
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_slot_in  = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_slot_in = '0;
                  pix_idx_in  = '0;
               end
            end
            CSR_IMAGE_WIDTH: begin
               if (csr_wdata[12:0] == 13'd0) begin
                  width_in = WW'(1);
               end else if (32'(csr_wdata[12:0]) > MAX_WIDTH) begin
                  width_in = WIDTH_MAX;
               end else begin
                  width_in = WW'(csr_wdata[12:0]);
               end
               in_col_in   = '0;
               in_row_in   = '0;
               in_slot_in  = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_slot_in = '0;
               pix_idx_in  = '0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in   = (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
               in_col_in   = '0;
               in_row_in   = '0;
               in_slot_in  = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_slot_in = '0;
               pix_idx_in  = '0;
            end
            default: begin
            end
         endcase
      end else begin
         if (pix_go) begin
            pix_idx_in = pix_idx_ff + PW'(1);
            if (in_col_end) begin
               in_col_in  = '0;
               in_row_in  = in_row_ff + 16'd1;
               in_slot_in = (32'(in_slot_ff) == RING - 1) ? '0 : in_slot_ff + SW'(1);
            end else begin
               in_col_in  = in_col_ff + XW'(1);
            end
         end
         if (emit_go) begin
            if (is_last) begin
               in_col_in   = '0;
               in_row_in   = '0;
               in_slot_in  = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               out_slot_in = '0;
               pix_idx_in  = '0;
            end else if (out_col_end) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + 16'd1;
               out_slot_in = (32'(out_slot_ff) == RING - 1) ? '0 : out_slot_ff + SW'(1);
            end else begin
               out_col_in  = out_col_ff + XW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= MASK_SIZE_RST;
         sel_ff      <= MASK_SEL_RST;
         width_ff    <= WIDTH_RST;
         height_ff   <= HEIGHT_RST;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         pix_idx_ff  <= '0;
      end else begin
         size_ff     <= size_in;
         sel_ff      <= sel_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
         pix_idx_ff  <= pix_idx_in;
      end
   end

   // Line store: one bank per stored row.
   pix_type rd_a [RING];
   pix_type rd_b [RING];

   for (genvar b = 0; b < RING; b++) begin : g_bank
      glb_line_bank #(
         .DEPTH (MAX_WIDTH)
      ) u_bank (
         .clock     (clock),
         .wr_en     (pix_go && (32'(in_slot_ff) == b)),
         .wr_addr   (in_col_ff),
         .wr_data   (pix_masked),
         .rd_addr_a (in_col_ff),
         .rd_data_a (rd_a[b]),
         .rd_addr_b (out_col_ff),
         .rd_data_b (rd_b[b])
      );
   end

   always_comb begin
      st1_in.shift    = pix_go;
      st1_in.emit     = emit_go;
      st1_in.interior = interior;
      st1_in.last     = is_last;
      st1_in.pix      = pix_masked;
      st1_in.yslot    = in_slot_ff;
      st1_in.oslot    = out_slot_ff;
   end

   always_comb begin
      tok_in[0].emit     = st1_ff.emit;
      tok_in[0].interior = st1_ff.interior;
      tok_in[0].last     = st1_ff.last;
      tok_in[0].pass     = rd_b[st1_ff.oslot];
      for (int i = 1; i < N_TOK; i++) begin
         tok_in[i] = tok_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= '0;
         tok_ff <= '{default: '0};
      end else begin
         st1_ff <= st1_in;
         tok_ff <= tok_in;
      end
   end

   // Window: a chain of column cells.
   logic [MAX_TAPS-1:0][PIX_W-1:0]  new_col;
   logic [MAX_TAPS-1:0][PIX_W-1:0]  col_out [MAX_TAPS];
   logic [MAX_TAPS-1:0][COEF_W-1:0] coef_vec;
   logic [VSUM_W-1:0]               vsum [MAX_TAPS];

   always_comb begin
      int slot;
      new_col[0] = st1_ff.pix;
      for (int j = 1; j < MAX_TAPS; j++) begin
         slot = (32'(st1_ff.yslot) >= j) ? 32'(st1_ff.yslot) - j
                                         : 32'(st1_ff.yslot) + RING - j;
         new_col[j] = rd_a[SW'(slot)];
      end
      for (int j = 0; j < MAX_TAPS; j++) begin
         coef_vec[j] = COEF_TAB[sel_ff][j];
      end
   end

   for (genvar c = 0; c < MAX_TAPS; c++) begin : g_cell
      glb_cell #(
         .TAPS (MAX_TAPS)
      ) u_cell (
         .clock    (clock),
         .shift_en (st1_ff.shift),
         .new_col  ((c == 0) ? new_col : col_out[(c == 0) ? 0 : c - 1]),
         .coef     (coef_vec),
         .col_out  (col_out[c]),
         .vsum     (vsum[c])
      );
   end

   // Horizontal weighting and rounding.
   logic [HPROD_W-1:0] hprod_ff [MAX_TAPS];
   logic [HPROD_W-1:0] hprod_in [MAX_TAPS];
   logic [ACC_W-1:0]   acc_ff, acc_in, acc_rnd;
   logic [RND_W-1:0]   acc_top;
   logic [PIX_W-1:0]   filt_val;

   always_comb begin
      acc_in = '0;
      for (int c = 0; c < MAX_TAPS; c++) begin
         hprod_in[c] = (coef_vec[c] == '0) ? '0
                                           : HPROD_W'(vsum[c]) * HPROD_W'(coef_vec[c]);
         acc_in      = acc_in + ACC_W'(hprod_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      hprod_ff <= hprod_in;
      acc_ff   <= acc_in;
   end

   assign acc_rnd  = acc_ff + RND_HALF;
   assign acc_top  = acc_rnd[ACC_W-1:32];
   assign filt_val = (acc_top > RND_W'(PIX_MAX)) ? PIX_MAX : acc_top[PIX_W-1:0];

   // Output queue.
   rsp_word_type    fifo_ff [FIFO_DEPTH];
   rsp_word_type    push_word;
   logic [FA_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FC_W-1:0] fifo_count_ff, fifo_count_in;
   logic [2:0]      inflight;
   logic [FC_W:0]   occupancy;
   logic            rsp_push, rsp_pop;

   assign rsp_push = tok_ff[N_TOK-1].emit;
   assign rsp_pop  = rsp_valid && !rsp_stall;
   assign push_word.pixel_out  = tok_ff[N_TOK-1].interior ? filt_val
                                                          : tok_ff[N_TOK-1].pass;
   assign push_word.frame_last = tok_ff[N_TOK-1].last;

   always_comb begin
      inflight = 3'(st1_ff.emit);
      for (int i = 0; i < N_TOK; i++) begin
         inflight = inflight + 3'(tok_ff[i].emit);
      end
      occupancy     = (FC_W + 1)'(fifo_count_ff) + (FC_W + 1)'(inflight);
      wr_ptr_in     = rsp_push ? wr_ptr_ff + FA_W'(1) : wr_ptr_ff;
      rd_ptr_in     = rsp_pop ? rd_ptr_ff + FA_W'(1) : rd_ptr_ff;
      fifo_count_in = fifo_count_ff + FC_W'(rsp_push) - FC_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   assign req_stall = occupancy >= (FC_W + 1)'(FIFO_DEPTH);
   assign rsp_valid = fifo_count_ff != '0;
   assign rsp_word  = fifo_ff[rd_ptr_ff];

   `GLB_ASSERT_ALWAYS(a_fifo_bound, clock, reset, fifo_count_ff <= FIFO_FULL)
   `GLB_ASSERT_IMPLY(a_push_room, clock, reset, rsp_push, (fifo_count_ff < FIFO_FULL) || rsp_pop)
   `GLB_ASSERT_NEXT(a_early_flush, clock, reset, req_acc && (req_word.op == OP_FLUSH) && !frame_done, !st1_ff.emit && !st1_ff.shift)

endmodule

>>> design/glb_line_bank.sv
// ----------------------------------------------------------------------------
// glb_line_bank
// One row of the line store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module glb_line_bank #(
   parameter int DEPTH = glb_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  glb_pkg::pix_type             wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr_a,
   output glb_pkg::pix_type             rd_data_a,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr_b,
   output glb_pkg::pix_type             rd_data_b
);
   import glb_pkg::*;

   pix_type mem [DEPTH];
   pix_type rd_a_ff;
   pix_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> design/glb_cell.sv
// ----------------------------------------------------------------------------
// glb_cell
// One window column: holds a column of pixels, passes it to the next cell
// on each shift, and forms the weighted vertical sum of its column.
// ----------------------------------------------------------------------------
module glb_cell #(
   parameter int TAPS = glb_pkg::MAX_TAPS_DEF
) (
   input  logic                                       clock,
   input  logic                                       shift_en,
   input  logic [TAPS-1:0][glb_pkg::PIX_W-1:0]        new_col,
   input  logic [TAPS-1:0][glb_pkg::COEF_W-1:0]       coef,
   output logic [TAPS-1:0][glb_pkg::PIX_W-1:0]        col_out,
   output logic [glb_pkg::VSUM_W-1:0]                 vsum
);
   import glb_pkg::*;

   logic [TAPS-1:0][PIX_W-1:0] col_ff, col_in;
   logic [PROD_W-1:0]          prod_ff [TAPS];
   logic [PROD_W-1:0]          prod_in [TAPS];
   logic [VSUM_W-1:0]          vsum_ff, vsum_in;

   // Taps outside the selected window carry a zero weight and contribute
   // nothing, whatever the column holds there.
   always_comb begin
      col_in  = shift_en ? new_col : col_ff;
      vsum_in = '0;
      for (int j = 0; j < TAPS; j++) begin
         prod_in[j] = (coef[j] == '0) ? '0 : PROD_W'(col_ff[j]) * PROD_W'(coef[j]);
         vsum_in    = vsum_in + VSUM_W'(prod_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      prod_ff <= prod_in;
      vsum_ff <= vsum_in;
   end

   assign col_out = col_ff;
   assign vsum    = vsum_ff;

endmodule
